// ----- hw/rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int unsigned DEPTH_DEF = 512;
	localparam int unsigned ITEM_W    = 32;
	localparam int unsigned COUNT_W   = 10;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_LOAD = 2'd2
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
		logic load;
	} cmd_t;

endpackage

// ----- hw/rtl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes a word, runs the operation, loads the result register.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   load_ok;

	// result register free now or emptied this cycle
	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: state_d = S_LOAD;
			S_LOAD: begin
				if (load_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_EXEC: cmd.execute = 1'b1;
			S_LOAD: cmd.load = load_ok;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/dq_datapath.sv -----
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, front and back pointers, count and result register.
// ----------------------------------------------------------------------------
module dq_datapath import dq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  op_t               opcode,
	input  logic [ITEM_W-1:0] item_value,
	output status_t           status,
	output logic [ITEM_W-1:0] popped_item,
	output logic [COUNT_W-1:0] item_count
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [ITEM_W-1:0] mem_q [DEPTH];

	op_t               op_q;
	logic [ITEM_W-1:0] value_q;
	logic [PTR_W-1:0]  front_q;
	logic [PTR_W-1:0]  back_q;
	logic [CNT_W-1:0]  count_q;
	status_t           op_status_q;
	logic              pop_ok_q;
	logic [ITEM_W-1:0] rd_data_q;

	status_t           status_q;
	logic [ITEM_W-1:0] popped_q;
	logic [COUNT_W-1:0] count_out_q;

	logic              is_push;
	logic              is_full;
	logic              is_empty;
	logic              wr_en;
	logic              rd_en;
	logic [PTR_W-1:0]  front_up;
	logic [PTR_W-1:0]  front_dn;
	logic [PTR_W-1:0]  back_up;
	logic [PTR_W-1:0]  back_dn;
	logic [PTR_W-1:0]  addr;

	assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
	assign is_full  = (count_q == CNT_FULL);
	assign is_empty = (count_q == '0);
	assign wr_en    = cmd.execute && is_push && !is_full;
	assign rd_en    = cmd.execute && !is_push && !is_empty;

	// pointers wrap at DEPTH, which need not be a power of two
	assign front_up = (front_q == PTR_LAST) ? '0 : front_q + 1'b1;
	assign front_dn = (front_q == '0) ? PTR_LAST : front_q - 1'b1;
	assign back_up  = (back_q == PTR_LAST) ? '0 : back_q + 1'b1;
	assign back_dn  = (back_q == '0) ? PTR_LAST : back_q - 1'b1;

	always_comb begin
		case (op_q)
			OP_PUSH_FRONT: addr = front_dn;
			OP_PUSH_BACK:  addr = back_q;
			OP_POP_FRONT:  addr = front_q;
			OP_POP_BACK:   addr = back_dn;
			default:       addr = front_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[addr] <= value_q;
		if (rd_en) rd_data_q <= mem_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			value_q <= item_value;
		end
		if (cmd.execute) begin
			pop_ok_q <= rd_en;
			if (is_push) op_status_q <= is_full ? ST_FULL : ST_DONE;
			else op_status_q <= is_empty ? ST_EMPTY : ST_DONE;
		end
		if (cmd.load) begin
			status_q    <= op_status_q;
			popped_q    <= pop_ok_q ? rd_data_q : '0;
			count_out_q <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			if (wr_en) begin
				count_q <= count_q + 1'b1;
				if (op_q == OP_PUSH_FRONT) front_q <= front_dn;
				else back_q <= back_up;
			end else if (rd_en) begin
				count_q <= count_q - 1'b1;
				if (op_q == OP_POP_FRONT) front_q <= front_up;
				else back_q <= back_dn;
			end
		end
	end

	assign status      = status_q;
	assign popped_item = popped_q;
	assign item_count  = count_out_q;

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit items in a ring store.
// ----------------------------------------------------------------------------
// a word is taken, executed with a registered store read, then loaded into the result register
// a new word is taken only once the previous one has been loaded
// a stalled result holds the engine in its load step until taken
// reset clears pointers, count and the output valid flag; the store is not cleared
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // item_value
	input  logic [1:0]  s_tuser,  // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // popped_item, item_count, zero fill
	output logic [1:0]  m_tuser   // status
);

	cmd_t                cmd;
	status_t             status;
	logic [ITEM_W-1:0]   popped_item;
	logic [COUNT_W-1:0]  item_count;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	dq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (op_t'(s_tuser)),
		.item_value  (s_tdata),
		.status      (status),
		.popped_item (popped_item),
		.item_count  (item_count)
	);

	assign m_tuser = status;
	assign m_tdata = {6'd0, item_count, popped_item};

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.execute, cmd.load}))
		else $error("more than one command at once");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> cmd.execute)
		else $error("accepted word not executed");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> m_tvalid)
		else $error("result loaded but not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> !s_tready)
		else $error("input taken while an operation runs");

endmodule

// ----- tb/double_ended_queue_test.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the double-ended queue: a mirror of the ring store
// predicts status, popped item and count for every word taken, and each
// result word is compared with the oldest prediction. Traffic fills the
// store past full, drains it past empty and mixes all four operations, with
// random gaps on the input side and random back-pressure on the output.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
	import dq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = DEPTH_DEF;
	localparam int          RANDOM_OPS  = 1900;
	localparam int          CALM_OPS    = 150;
	localparam int          STALL_LIMIT = 2000;
	localparam int          OVERSHOOT   = 6;
	localparam int          MIX_OPS     = 150;

	typedef enum logic [1:0] {
		PH_FILL  = 2'd0,
		PH_DRAIN = 2'd1,
		PH_MIX   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ITEM_W-1:0] item;
		logic [COUNT_W-1:0] count;
	} deque_result_t;

	class deque_mirror;
		logic [ITEM_W-1:0] ring [DEPTH];
		logic [8:0]        head;
		logic [8:0]        tail;
		logic [COUNT_W-1:0] held;
		deque_result_t     pending_results [$];
		int                errors;

		function new();
			head   = '0;
			tail   = '0;
			held   = '0;
			errors = 0;
		endfunction

		function void apply_op(op_t op, logic [ITEM_W-1:0] value);
			deque_result_t r;
			r.status = ST_DONE;
			r.item   = '0;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (held == DEPTH) begin
						r.status = ST_FULL;
					end else if (op == OP_PUSH_FRONT) begin
						head = (head == 0) ? 9'(DEPTH - 1) : head - 1'b1;
						ring[head] = value;
						held++;
					end else begin
						ring[tail] = value;
						tail = (tail == DEPTH - 1) ? '0 : tail + 1'b1;
						held++;
					end
				end
				default: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (op == OP_POP_FRONT) begin
						r.item = ring[head];
						head = (head == DEPTH - 1) ? '0 : head + 1'b1;
						held--;
					end else begin
						tail = (tail == 0) ? 9'(DEPTH - 1) : tail - 1'b1;
						r.item = ring[tail];
						held--;
					end
				end
			endcase
			r.count = held;
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void compare_word(logic [1:0] status, logic [ITEM_W-1:0] item,
				logic [COUNT_W-1:0] count, logic [5:0] fill);
			deque_result_t r;
			if (pending_results.size() == 0) begin
				$error("result word with nothing outstanding: status %0d item %0h count %0d",
					status, item, count);
				errors++;
				return;
			end
			r = pending_results[0];
			pending_results.delete(0);
			if (status !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, status);
				errors++;
			end
			if (item !== r.item) begin
				$error("popped_item: expected %0h, got %0h", r.item, item);
				errors++;
			end
			if (count !== r.count) begin
				$error("item_count: expected %0d, got %0d", r.count, count);
				errors++;
			end
			if (fill !== '0) begin
				$error("zero fill: expected 0, got %0h", fill);
				errors++;
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	bit          calm = 1'b0;
	int          stall_cycles = 0;
	deque_mirror mirror = new();

	always #5ns clk = ~clk;

	double_ended_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// handshakes seen with pre-edge values, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			mirror.apply_op(op_t'(s_tuser), s_tdata);
		if (arst_n && m_tvalid && m_tready)
			mirror.compare_word(m_tuser, m_tdata[31:0], m_tdata[41:32], m_tdata[47:42]);
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// output back-pressure in bursts, none once the run goes calm
	initial begin
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	task automatic send_word(input op_t op, input logic [31:0] value);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		phase_t phase;
		op_t    op;
		bit     grow;
		int     level;
		int     overshoot;
		int     mix_left;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops at both ends, extremes pushed at both ends, then drained
		send_word(OP_POP_FRONT, $urandom());
		send_word(OP_POP_BACK, $urandom());
		send_word(OP_PUSH_FRONT, 32'h8000_0000);
		send_word(OP_PUSH_BACK, 32'h7FFF_FFFF);
		send_word(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		send_word(OP_PUSH_BACK, 32'h0000_0000);
		send_word(OP_PUSH_FRONT, 32'h0000_0001);
		send_word(OP_POP_BACK, $urandom());
		send_word(OP_POP_FRONT, $urandom());
		send_word(OP_PUSH_BACK, 32'hA5A5_5A5A);
		send_word(OP_POP_FRONT, $urandom());
		send_word(OP_POP_BACK, $urandom());
		send_word(OP_POP_FRONT, $urandom());
		send_word(OP_POP_BACK, $urandom());
		send_word(OP_POP_FRONT, $urandom());
		send_word(OP_POP_BACK, $urandom());

		// fill past full, drain past empty, then a mixed stretch, repeated
		level     = 0;
		phase     = PH_FILL;
		overshoot = 0;
		mix_left  = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n >= RANDOM_OPS - CALM_OPS)
				calm = 1'b1;
			case (phase)
				PH_FILL:  grow = $urandom_range(0, 7) != 0;
				PH_DRAIN: grow = $urandom_range(0, 7) == 0;
				default:  grow = $urandom_range(0, 1) != 0;
			endcase
			if (grow)
				op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			if ((phase == PH_FILL && grow && level == DEPTH) ||
					(phase == PH_DRAIN && !grow && level == 0))
				overshoot++;
			if (grow && level < DEPTH)
				level++;
			else if (!grow && level > 0)
				level--;
			case (phase)
				PH_FILL: begin
					if (overshoot >= OVERSHOOT) begin
						phase     = PH_DRAIN;
						overshoot = 0;
					end
				end
				PH_DRAIN: begin
					if (overshoot >= OVERSHOOT) begin
						phase     = PH_MIX;
						overshoot = 0;
						mix_left  = MIX_OPS;
					end
				end
				default: begin
					mix_left--;
					if (mix_left == 0)
						phase = PH_FILL;
				end
			endcase
			send_word(op, pick_value());
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (mirror.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mirror.pending_results.size() != 0) begin
			$error("%0d result words never arrived", mirror.pending_results.size());
			mirror.errors++;
		end
		if (mirror.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
tb/double_ended_queue_test.sv
